[rtl/core/rfmc_pkg.sv]
// types and codes shared by the ring fifo with match count
package rfmc_pkg;

	localparam logic [1:0] FUNC_ENQ = 2'd0;
	localparam logic [1:0] FUNC_DEQ = 2'd1;
	localparam logic [1:0] FUNC_CNT = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam int          CNT_W   = 5;
	localparam logic [4:0]  CNT_MAX = 5'd31;
	localparam int          WORD_W  = 32;
	localparam int          CAP_W   = 5;
	localparam logic [4:0]  CAP_RST = 5'd16;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] front_value;
		logic                     is_empty;
		logic [CNT_W-1:0]         match_count;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic              active;
		logic [WORD_W-1:0] value;
		logic [CNT_W-1:0]  count;
	} tok_t;

	typedef enum logic {
		ST_IDLE,
		ST_COUNT
	} state_t;

endpackage

[rtl/core/rfmc_cell.sv]
// one queue cell: holds one entry and adds its match to the passing count token
module rfmc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rfmc_pkg::cell_ctl_t           ctl,
	input  logic [rfmc_pkg::WORD_W-1:0]   load_data,
	input  logic [rfmc_pkg::WORD_W-1:0]   next_data,
	input  logic                          occupied,
	input  rfmc_pkg::tok_t                tok_in,
	output logic [rfmc_pkg::WORD_W-1:0]   data,
	output rfmc_pkg::tok_t                tok_out
);

	logic [rfmc_pkg::WORD_W-1:0] data_q;
	logic                        active_q;
	logic [rfmc_pkg::WORD_W-1:0] value_q;
	logic [rfmc_pkg::CNT_W-1:0]  count_q;
	logic                        hit;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	assign hit = occupied && (data_q == tok_in.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= tok_in.active;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= tok_in.value;
		if (hit && tok_in.count != rfmc_pkg::CNT_MAX) begin
			count_q <= tok_in.count + rfmc_pkg::CNT_W'(1);
		end else begin
			count_q <= tok_in.count;
		end
	end

	assign data           = data_q;
	assign tok_out.active = active_q;
	assign tok_out.value  = value_q;
	assign tok_out.count  = count_q;

endmodule

[rtl/core/ring_fifo_with_match_count.sv]
// top level: fifo as a shifting chain of cells with a walking match count token
// results: enqueue, dequeue and unused ops are registered in res_q, then in out_q
// accept: a new op stalls while the result register ahead of the output holds a result
// count: result loaded once the token has walked all DEPTH cells, one cell per cycle
// reset: queue empty, capacity 16; entry contents undefined, no clearing pass
// a capacity write empties the queue and is always taken, as cfg_ready is tied high
module ring_fifo_with_match_count #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  rfmc_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output rfmc_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rfmc_pkg::CAP_W-1:0]   cfg_data
);

	localparam int OW = $clog2(DEPTH + 1);
	localparam int EW = (OW > rfmc_pkg::CAP_W) ? OW : rfmc_pkg::CAP_W;
	localparam int NX = (DEPTH > 1) ? 1 : 0;

	logic [rfmc_pkg::CAP_W-1:0]  cap_q;
	logic [OW-1:0]               occ_q;
	rfmc_pkg::state_t            state_q, state_d;
	rfmc_pkg::rsp_t              res_q, out_q, res_d;
	logic                        res_valid_q, out_valid_q;

	logic [EW-1:0]               cap_e, occ_e;
	logic                        full, empty, accept, cfg_wr, out_free;
	logic                        enq_ok, deq_ok, res_load, cnt_start;
	logic [rfmc_pkg::WORD_W-1:0] front_now;

	logic [rfmc_pkg::WORD_W-1:0] cell_data [DEPTH];
	rfmc_pkg::tok_t              tok [DEPTH+1];
	rfmc_pkg::cell_ctl_t         ctl [DEPTH];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign cap_e = (cap_q == '0) ? EW'(1) :
		((EW'(cap_q) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(cap_q));
	assign occ_e = EW'(occ_q);
	assign full  = occ_e >= cap_e;
	assign empty = occ_q == '0;

	assign accept = req_valid && !req_stall;
	assign enq_ok = accept && req.func == rfmc_pkg::FUNC_ENQ && !full;
	assign deq_ok = accept && req.func == rfmc_pkg::FUNC_DEQ && !empty;
	assign front_now = empty ? '0 : cell_data[0];

	assign tok[0].active = cnt_start;
	assign tok[0].value  = req.value;
	assign tok[0].count  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i].load  = enq_ok && (OW'(i) == occ_q);
		assign ctl[i].shift = deq_ok;

		rfmc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.load_data (req.value),
			.next_data (cell_data[(i + 1 < DEPTH) ? i + 1 : i]),
			.occupied  (OW'(i) < occ_q),
			.tok_in    (tok[i]),
			.data      (cell_data[i]),
			.tok_out   (tok[i+1])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rfmc_pkg::ST_IDLE: begin
				if (accept && req.func == rfmc_pkg::FUNC_CNT) begin
					state_d = rfmc_pkg::ST_COUNT;
				end
			end
			rfmc_pkg::ST_COUNT: begin
				if (tok[DEPTH].active) begin
					state_d = rfmc_pkg::ST_IDLE;
				end
			end
			default: state_d = rfmc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the control
	always_comb begin
		req_stall = 1'b1;
		cnt_start = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			rfmc_pkg::ST_IDLE: begin
				req_stall = res_valid_q;
				cnt_start = accept && req.func == rfmc_pkg::FUNC_CNT;
				res_load  = accept && req.func != rfmc_pkg::FUNC_CNT;
			end
			rfmc_pkg::ST_COUNT: begin
				res_load = tok[DEPTH].active;
			end
			default: ;
		endcase
	end

	// result of the op, seen on the state before it takes effect
	always_comb begin
		res_d.status      = rfmc_pkg::STATUS_OK;
		res_d.front_value = front_now;
		res_d.is_empty    = empty;
		res_d.match_count = '0;
		if (state_q == rfmc_pkg::ST_COUNT) begin
			res_d.match_count = tok[DEPTH].count;
		end else begin
			case (req.func)
				rfmc_pkg::FUNC_ENQ: begin
					if (full) begin
						res_d.status = rfmc_pkg::STATUS_FULL;
					end else begin
						res_d.front_value = empty ? req.value : cell_data[0];
						res_d.is_empty    = 1'b0;
					end
				end
				rfmc_pkg::FUNC_DEQ: begin
					if (empty) begin
						res_d.status = rfmc_pkg::STATUS_EMPTY;
					end else begin
						res_d.front_value = (occ_q > OW'(1)) ? cell_data[NX] : '0;
						res_d.is_empty    = occ_q == OW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfmc_pkg::ST_IDLE;
			cap_q   <= rfmc_pkg::CAP_RST;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				cap_q <= cfg_data;
				occ_q <= '0;
			end else if (enq_ok) begin
				occ_q <= occ_q + OW'(1);
			end else if (deq_ok) begin
				occ_q <= occ_q - OW'(1);
			end
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_free) begin
				res_valid_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= res_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_free && res_valid_q) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	// a new result never lands on one still waiting
	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !res_valid_q)
		else $error("result register overwritten");

	// the count token only leaves the chain while a count is running
	a_tok_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		tok[DEPTH].active |-> state_q == rfmc_pkg::ST_COUNT)
		else $error("count token outside count");

	// occupancy never exceeds DEPTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_e <= EW'(DEPTH))
		else $error("occupancy beyond depth");

	// an empty queue reports a zero front
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_empty) |-> rsp.front_value == '0)
		else $error("nonzero front on empty queue");

	// no item is taken while a count walks the chain
	a_no_accept_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_start |=> req_stall)
		else $error("item accepted during count");
`endif

endmodule

[test/tb_ring_fifo_with_match_count.sv]
// self-checking testbench: ring fifo with match count against a queue model, random stalls
module tb_ring_fifo_with_match_count;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH     = 16;
	localparam int         IW        = $clog2(DEPTH);
	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	rfmc_pkg::req_t             req       = '0;
	logic                       rsp_valid;
	logic                       rsp_stall = 1'b0;
	rfmc_pkg::rsp_t             rsp;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [rfmc_pkg::CAP_W-1:0] cfg_data  = '0;

	ring_fifo_with_match_count #(.DEPTH(DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// queue model state
	logic [rfmc_pkg::WORD_W-1:0] ring_mem [DEPTH];
	int                          head_pos = 0;
	int                          tail_pos = 0;
	int                          fill_lvl = 0;
	logic [rfmc_pkg::CAP_W-1:0]  cap_reg  = rfmc_pkg::CAP_RST;

	rfmc_pkg::req_t              req_pend_q[$];
	logic [rfmc_pkg::CAP_W-1:0]  cap_pend_q[$];
	rfmc_pkg::rsp_t              rsp_expect_q[$];
	int                          reqs_sent  = 0;
	int                          reqs_taken = 0;
	int                          caps_sent  = 0;
	int                          caps_taken = 0;
	int                          err_cnt    = 0;
	int                          idle_pct   = 33;

	initial forever #4 clk = ~clk;

	function automatic int cap_span();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return int'(cap_reg);
	endfunction

	function automatic int wrap_next(int i);
		return (i + 1 >= cap_span()) ? 0 : i + 1;
	endfunction

	function automatic rfmc_pkg::rsp_t fifo_predict(rfmc_pkg::req_t r);
		rfmc_pkg::rsp_t o;
		int             idx;
		int             hits;
		o    = '0;
		hits = 0;
		case (r.func)
			rfmc_pkg::FUNC_ENQ: begin
				if (fill_lvl < cap_span()) begin
					ring_mem[IW'(tail_pos)] = r.value;
					tail_pos = wrap_next(tail_pos);
					fill_lvl++;
				end else begin
					o.status = rfmc_pkg::STATUS_FULL;
				end
			end
			rfmc_pkg::FUNC_DEQ: begin
				if (fill_lvl > 0) begin
					fill_lvl--;
					head_pos = wrap_next(head_pos);
				end else begin
					o.status = rfmc_pkg::STATUS_EMPTY;
				end
			end
			rfmc_pkg::FUNC_CNT: begin
				idx = head_pos;
				for (int k = 0; k < fill_lvl; k++) begin
					if (ring_mem[IW'(idx)] == r.value)
						hits++;
					idx = wrap_next(idx);
				end
			end
			default: ;
		endcase
		if (fill_lvl > 0)
			o.front_value = ring_mem[IW'(head_pos)];
		o.is_empty    = (fill_lvl == 0);
		o.match_count = (hits > rfmc_pkg::CNT_MAX) ? rfmc_pkg::CNT_MAX :
			hits[rfmc_pkg::CNT_W-1:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// request and capacity driver
	always @(posedge clk) begin
		logic                       nv;
		rfmc_pkg::req_t             nr;
		logic                       cv;
		logic [rfmc_pkg::CAP_W-1:0] cd;
		nv = req_valid;
		nr = req;
		cv = cfg_valid;
		cd = cfg_data;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cap_reg  = cfg_data;
				head_pos = 0;
				tail_pos = 0;
				fill_lvl = 0;
				caps_taken++;
				cv = 1'b0;
			end
			if (!cv && cap_pend_q.size() != 0) begin
				cd = cap_pend_q.pop_front();
				cv = 1'b1;
			end
			if (req_valid && !req_stall) begin
				rsp_expect_q.push_back(fifo_predict(req));
				reqs_taken++;
				nv = 1'b0;
			end
			if (!nv && req_pend_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nr = req_pend_q.pop_front();
				nv = 1'b1;
			end
		end
		req_valid <= nv;
		req       <= nr;
		cfg_valid <= cv;
		cfg_data  <= cd;
	end

	// result beat checker
	always @(posedge clk) begin
		rfmc_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expect_q.size() == 0) begin
				report_mismatch("unexpected beat", rsp.front_value, '0);
			end else begin
				want = rsp_expect_q.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.front_value !== want.front_value)
					report_mismatch("front_value", rsp.front_value, want.front_value);
				if (rsp.is_empty !== want.is_empty)
					report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
				if (rsp.match_count !== want.match_count)
					report_mismatch("match_count", 32'(rsp.match_count),
						32'(want.match_count));
			end
		end
		rsp_stall <= arst_n && ($urandom_range(0, 99) < idle_pct);
	end

	task automatic send_op(logic [1:0] func, logic [rfmc_pkg::WORD_W-1:0] value);
		rfmc_pkg::req_t r;
		r.func  = func;
		r.value = value;
		req_pend_q.push_back(r);
		reqs_sent++;
	endtask

	task automatic wait_drain();
		while (reqs_taken != reqs_sent || rsp_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cap(logic [rfmc_pkg::CAP_W-1:0] cap);
		wait_drain();
		cap_pend_q.push_back(cap);
		caps_sent++;
		while (caps_taken != caps_sent)
			@(posedge clk);
	endtask

	initial begin
		logic [rfmc_pkg::CAP_W-1:0]  caps [12];
		logic [rfmc_pkg::WORD_W-1:0] pool [4];
		int                          enq_w;
		int                          deq_w;
		int                          pick;
		logic [1:0]                  fn;
		logic [rfmc_pkg::WORD_W-1:0] val;
		caps = '{5'd0, 5'd16, 5'd31, 5'd3, 5'd17, 5'd1, 5'd8, 5'd16,
			5'd2, 5'd5, 5'd12, 5'd30};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue corners and extreme words at reset capacity
		send_op(rfmc_pkg::FUNC_DEQ, 32'h0);
		send_op(rfmc_pkg::FUNC_CNT, 32'h0);
		send_op(FUNC_NONE, 32'h0);
		send_op(rfmc_pkg::FUNC_ENQ, 32'h8000_0000);
		send_op(rfmc_pkg::FUNC_ENQ, 32'h7fff_ffff);
		send_op(rfmc_pkg::FUNC_ENQ, 32'h0);
		send_op(rfmc_pkg::FUNC_ENQ, 32'hffff_ffff);
		send_op(rfmc_pkg::FUNC_ENQ, 32'hffff_ffff);
		send_op(rfmc_pkg::FUNC_CNT, 32'hffff_ffff);
		send_op(rfmc_pkg::FUNC_CNT, 32'h8000_0000);
		send_op(rfmc_pkg::FUNC_CNT, 32'h0001_2345);
		send_op(FUNC_NONE, 32'h5a5a_5a5a);
		send_op(rfmc_pkg::FUNC_DEQ, 32'h0);

		// single slot: full and empty errors
		write_cap(5'd1);
		send_op(rfmc_pkg::FUNC_ENQ, 32'ha5a5_a5a5);
		send_op(rfmc_pkg::FUNC_ENQ, 32'h1);
		send_op(rfmc_pkg::FUNC_CNT, 32'ha5a5_a5a5);
		send_op(rfmc_pkg::FUNC_DEQ, 32'h0);
		send_op(rfmc_pkg::FUNC_DEQ, 32'h0);
		send_op(rfmc_pkg::FUNC_ENQ, 32'h7fff_ffff);

		// two slots: full, then wrap of the ring
		write_cap(5'd2);
		send_op(rfmc_pkg::FUNC_ENQ, 32'd11);
		send_op(rfmc_pkg::FUNC_ENQ, 32'd22);
		send_op(rfmc_pkg::FUNC_ENQ, 32'd33);
		send_op(rfmc_pkg::FUNC_DEQ, 32'h0);
		send_op(rfmc_pkg::FUNC_ENQ, 32'd22);
		send_op(rfmc_pkg::FUNC_CNT, 32'd22);

		for (int ph = 0; ph < 12; ph++) begin
			write_cap(ph < 8 ? caps[4'(ph)] : rfmc_pkg::CAP_W'($urandom_range(0, 31)));
			idle_pct = (ph == 3) ? 0 : 33;
			pool[0] = $urandom();
			pool[1] = $urandom();
			pool[2] = $urandom_range(0, 3);
			pool[3] = (ph % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
			for (int n = 0; n < 108; n++) begin
				// fill during the first half, drain during the second
				enq_w = (n < 54) ? 60 : 25;
				deq_w = (n < 54) ? 18 : 53;
				pick  = $urandom_range(0, 99);
				if (pick < enq_w)
					fn = rfmc_pkg::FUNC_ENQ;
				else if (pick < enq_w + deq_w)
					fn = rfmc_pkg::FUNC_DEQ;
				else if (pick < 97)
					fn = rfmc_pkg::FUNC_CNT;
				else
					fn = FUNC_NONE;
				val = ($urandom_range(0, 99) < 60) ? pool[2'($urandom_range(0, 3))] :
					$urandom();
				send_op(fn, val);
				if (ph == 5 && n == 54)
					wait_drain();
			end
		end

		wait_drain();
		repeat (DEPTH + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/rfmc_pkg.sv
rtl/core/rfmc_cell.sv
rtl/core/ring_fifo_with_match_count.sv
test/tb_ring_fifo_with_match_count.sv
